### sv/rsc_pkg.sv
// shared types and constants for the ray to sphere cast pipeline
// no dependencies
package rsc_pkg;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MOTION_EPS = 2'd0;
    localparam t_reg_idx REG_CENTER_EPS = 2'd1;

    localparam logic [30:0] Q_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        KIND_MISS,
        KIND_MOVE,
        KIND_STAT
    } t_kind;

    typedef logic [2:0][31:0] t_vec3;

    typedef struct packed {
        t_vec3       m;
        t_vec3       p;
        t_vec3       d;
        logic [30:0] rad;
    } t_ray;

    typedef struct packed {
        t_ray        ray;
        logic [63:0] a;
        logic [63:0] mm;
        logic [63:0] bmag;
        logic        bneg;
        logic        in_sph;
        logic        still;
        logic        center;
        logic        miss;
    } t_front;

    typedef struct packed {
        t_ray  ray;
        t_kind kind;
        logic  center;
    } t_mid;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sgn;

    typedef struct packed {
        t_kind       kind;
        logic        center;
        logic [30:0] hit_t;
        t_vec3       point;
        t_sgn        sx;
    } t_tail;

endpackage

### sv/rsc_sqrt.sv
// pipelined floor square root, one root bit per stage, with sideband
// standalone, no package use
module rsc_sqrt #(
    parameter int RB = 32,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [2*RB-1:0] i_val,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RB-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    localparam int RW = RB + 3;

    logic            r_vld  [RB];
    logic [2*RB-1:0] r_val  [RB];
    logic [RW-1:0]   r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [SW-1:0]   r_side [RB];

    for (genvar g = 0; g < RB; g++) begin : g_stage
        logic            src_vld;
        logic [2*RB-1:0] src_val;
        logic [RW-1:0]   src_rem;
        logic [RB-1:0]   src_root;
        logic [SW-1:0]   src_side;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;
        logic            ge;

        if (g == 0) begin : g_first
            assign src_vld  = i_vld;
            assign src_val  = i_val;
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_side = i_side;
        end else begin : g_next
            assign src_vld  = r_vld[g-1];
            assign src_val  = r_val[g-1];
            assign src_rem  = r_rem[g-1];
            assign src_root = r_root[g-1];
            assign src_side = r_side[g-1];
        end

        assign rem_sh = {src_rem[RW-3:0], src_val[2*RB-1 -: 2]};
        assign trial  = {1'b0, src_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_val[g]  <= src_val << 2;
            r_rem[g]  <= ge ? rem_sh - trial : rem_sh;
            r_root[g] <= {src_root[RB-2:0], ge};
            r_side[g] <= src_side;
        end
    end

    assign o_vld  = r_vld[RB-1];
    assign o_root = r_root[RB-1];
    assign o_side = r_side[RB-1];

endmodule

### sv/rsc_div.sv
// pipelined restoring divider, one quotient bit per stage, saturation flag
// standalone, no package use
module rsc_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = 31,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QB-1:0] o_quo,
    output logic          o_sat,
    output logic [SW-1:0] o_side
);

    localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic          r_vld  [QB+1];
    logic [CW-1:0] r_rem  [QB+1];
    logic [DW-1:0] r_den  [QB+1];
    logic [QB-1:0] r_quo  [QB+1];
    logic          r_sat  [QB+1];
    logic [SW-1:0] r_side [QB+1];

    // quotient of 2^QB or more flagged up front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= CW'(i_num);
        r_den[0]  <= i_den;
        r_quo[0]  <= '0;
        r_sat[0]  <= CW'(i_num) >= (CW'(i_den) << QB);
        r_side[0] <= i_side;
    end

    for (genvar g = 1; g <= QB; g++) begin : g_stage
        localparam int SH = QB - g;
        logic [CW-1:0] dsh;
        logic          ge;

        assign dsh = CW'(r_den[g-1]) << SH;
        assign ge  = r_rem[g-1] >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= ge ? r_rem[g-1] - dsh : r_rem[g-1];
            r_den[g]  <= r_den[g-1];
            r_quo[g]  <= {r_quo[g-1][QB-2:0], ge};
            r_sat[g]  <= r_sat[g-1];
            r_side[g] <= r_side[g-1];
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_quo  = r_quo[QB];
    assign o_sat  = r_sat[QB];
    assign o_side = r_side[QB];

endmodule

### sv/ray_sphere_cast.sv
// top level: moving point against sphere, fixed point, fully pipelined
// depends on rsc_pkg, rsc_sqrt, rsc_div
// one request accepted every cycle while busy is low, each result marked by o_done
// depth set by the 64-stage discriminant square root and two levels of 32-stage dividers
// synchronous active-low reset clears all valid bits; epsilons reset to 1
// busy is high during reset and for the first cycle after it; results cannot be held off
module ray_sphere_cast
    import rsc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  t_reg_idx           i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    input  logic signed [31:0] i_offset_z,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_dir_x,
    input  logic signed [31:0] i_dir_y,
    input  logic signed [31:0] i_dir_z,
    input  logic [30:0]        i_sphere_radius,
    output logic               o_done,
    output logic               o_hit,
    output logic [30:0]        o_hit_time,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic signed [31:0] o_normal_x,
    output logic signed [31:0] o_normal_y,
    output logic signed [31:0] o_normal_z
);

    localparam int NUMW    = 64 + FRAC_BITS;
    localparam int SQRT_RB = 64;
    localparam int DIV_QB  = 31;
    localparam int LAT     = 6 + SQRT_RB + 1 + (DIV_QB + 1) + 2 + (DIV_QB + 1) + 1;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] norm_q(input logic [30:0] q, input logic sat,
                                           input t_sgn s);
        logic [31:0] v;
        v = {1'b0, q};
        if (s.zero) begin
            return '0;
        end
        if (sat) begin
            return s.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s.neg ? -v : v;
    endfunction

    // configuration and handshake
    logic        r_motion_eps_en;
    logic [31:0] r_motion_eps;
    logic [31:0] r_center_eps;
    logic        r_busy;
    logic        w_acc;

    assign busy  = r_busy;
    assign w_acc = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b1;
            r_motion_eps    <= 32'd1;
            r_center_eps    <= 32'd1;
            r_motion_eps_en <= 1'b0;
        end else begin
            r_busy          <= 1'b0;
            r_motion_eps_en <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MOTION_EPS: begin
                        r_motion_eps    <= i_cfg_wdata;
                        r_motion_eps_en <= 1'b1;
                    end
                    REG_CENTER_EPS: r_center_eps <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // valid bits
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic r_s7_vld, r_s8_vld, r_s9_vld, r_out_vld;
    logic w_sq_vld, w_td_vld, w_nd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= w_acc;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= w_sq_vld;
            r_s8_vld  <= w_td_vld;
            r_s9_vld  <= r_s8_vld;
            r_out_vld <= w_nd_vld;
        end
    end

    // stage 1: component products
    t_ray               w_ray;
    logic signed [63:0] n_s1_dd [3];
    logic signed [63:0] n_s1_mm [3];
    logic signed [63:0] n_s1_md [3];
    logic [61:0]        n_s1_r2;
    logic signed [63:0] r_s1_dd [3];
    logic signed [63:0] r_s1_mm [3];
    logic signed [63:0] r_s1_md [3];
    logic [61:0]        r_s1_r2;
    t_ray               r_s1_ray;

    assign w_ray.m   = {i_offset_z, i_offset_y, i_offset_x};
    assign w_ray.p   = {i_start_z, i_start_y, i_start_x};
    assign w_ray.d   = {i_dir_z, i_dir_y, i_dir_x};
    assign w_ray.rad = i_sphere_radius;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s1_dd[i] = $signed(w_ray.d[i]) * $signed(w_ray.d[i]);
            n_s1_mm[i] = $signed(w_ray.m[i]) * $signed(w_ray.m[i]);
            n_s1_md[i] = $signed(w_ray.m[i]) * $signed(w_ray.d[i]);
        end
        n_s1_r2 = 62'(i_sphere_radius) * 62'(i_sphere_radius);
    end

    always_ff @(posedge i_clk) begin
        r_s1_dd  <= n_s1_dd;
        r_s1_mm  <= n_s1_mm;
        r_s1_md  <= n_s1_md;
        r_s1_r2  <= n_s1_r2;
        r_s1_ray <= w_ray;
    end

    // stage 2: dot products
    logic [63:0] n_s2_a, n_s2_mm, n_s2_bpos, n_s2_bneg;
    logic [63:0] r_s2_a, r_s2_mm, r_s2_bpos, r_s2_bneg;
    logic [61:0] r_s2_r2;
    t_ray        r_s2_ray;

    always_comb begin
        n_s2_a    = 64'(r_s1_dd[0] + r_s1_dd[1] + r_s1_dd[2]);
        n_s2_mm   = 64'(r_s1_mm[0] + r_s1_mm[1] + r_s1_mm[2]);
        n_s2_bpos = '0;
        n_s2_bneg = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_s1_md[i] >= 0) begin
                n_s2_bpos = n_s2_bpos + 64'(r_s1_md[i]);
            end else begin
                n_s2_bneg = n_s2_bneg + 64'(-r_s1_md[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_a    <= n_s2_a;
        r_s2_mm   <= n_s2_mm;
        r_s2_bpos <= n_s2_bpos;
        r_s2_bneg <= n_s2_bneg;
        r_s2_r2   <= r_s1_r2;
        r_s2_ray  <= r_s1_ray;
    end

    // stage 3: b and c magnitudes, start-in-sphere test, stationary test, center test
    t_front      n_s3_ctl;
    logic [63:0] n_s3_cmag;
    t_front      r_s3_ctl;
    logic [63:0] r_s3_cmag;

    always_comb begin
        n_s3_ctl.ray    = r_s2_ray;
        n_s3_ctl.a      = r_s2_a;
        n_s3_ctl.mm     = r_s2_mm;
        n_s3_ctl.bneg   = r_s2_bneg > r_s2_bpos;
        n_s3_ctl.bmag   = n_s3_ctl.bneg ? r_s2_bneg - r_s2_bpos : r_s2_bpos - r_s2_bneg;
        n_s3_ctl.in_sph = r_s2_mm <= 64'(r_s2_r2);
        n_s3_ctl.still  = (r_s2_a == '0) || (r_s2_a < 64'(r_motion_eps));
        n_s3_ctl.center = r_s2_mm > 64'(r_center_eps);
        n_s3_ctl.miss   = 1'b0;
        n_s3_cmag       = n_s3_ctl.in_sph ? 64'(r_s2_r2) - r_s2_mm : r_s2_mm - 64'(r_s2_r2);
    end

    always_ff @(posedge i_clk) begin
        r_s3_ctl  <= n_s3_ctl;
        r_s3_cmag <= n_s3_cmag;
    end

    // stage 4: partial products of b*b and a*c
    t_front      r_s4_ctl;
    logic [63:0] r_s4_b_ll, r_s4_b_lh, r_s4_b_hh;
    logic [63:0] r_s4_c_ll, r_s4_c_lh, r_s4_c_hl, r_s4_c_hh;

    always_ff @(posedge i_clk) begin
        r_s4_ctl  <= r_s3_ctl;
        r_s4_b_ll <= 64'(r_s3_ctl.bmag[31:0]) * 64'(r_s3_ctl.bmag[31:0]);
        r_s4_b_lh <= 64'(r_s3_ctl.bmag[31:0]) * 64'(r_s3_ctl.bmag[63:32]);
        r_s4_b_hh <= 64'(r_s3_ctl.bmag[63:32]) * 64'(r_s3_ctl.bmag[63:32]);
        r_s4_c_ll <= 64'(r_s3_ctl.a[31:0]) * 64'(r_s3_cmag[31:0]);
        r_s4_c_lh <= 64'(r_s3_ctl.a[31:0]) * 64'(r_s3_cmag[63:32]);
        r_s4_c_hl <= 64'(r_s3_ctl.a[63:32]) * 64'(r_s3_cmag[31:0]);
        r_s4_c_hh <= 64'(r_s3_ctl.a[63:32]) * 64'(r_s3_cmag[63:32]);
    end

    // stage 5: full products
    t_front       r_s5_ctl;
    logic [127:0] r_s5_b2, r_s5_ac;

    always_ff @(posedge i_clk) begin
        r_s5_ctl <= r_s4_ctl;
        r_s5_b2  <= {r_s4_b_hh, r_s4_b_ll} + ({64'b0, r_s4_b_lh} << 33);
        r_s5_ac  <= {r_s4_c_hh, r_s4_c_ll} + ({64'b0, r_s4_c_lh} << 32)
                    + ({64'b0, r_s4_c_hl} << 32);
    end

    // stage 6: discriminant
    t_front       n_s6_ctl;
    t_front       r_s6_ctl;
    logic [127:0] r_s6_disc;

    always_comb begin
        n_s6_ctl      = r_s5_ctl;
        n_s6_ctl.miss = !r_s5_ctl.in_sph && (r_s5_b2 < r_s5_ac);
    end

    always_ff @(posedge i_clk) begin
        r_s6_ctl  <= n_s6_ctl;
        r_s6_disc <= r_s5_ctl.in_sph ? r_s5_b2 + r_s5_ac : r_s5_b2 - r_s5_ac;
    end

    logic [SQRT_RB-1:0]       w_sq_root;
    logic [$bits(t_front)-1:0] w_sq_side;
    t_front                   w_sq_ctl;

    rsc_sqrt #(
        .RB (SQRT_RB),
        .SW ($bits(t_front))
    ) u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s6_vld),
        .i_val   (r_s6_disc),
        .i_side  (r_s6_ctl),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_side  (w_sq_side)
    );

    assign w_sq_ctl = t_front'(w_sq_side);

    // stage 7: classify the request
    t_mid            n_s7_mid;
    t_mid            r_s7_mid;
    logic [NUMW-1:0] r_s7_num;
    logic [63:0]     r_s7_a;
    logic [63:0]     r_s7_mm;

    always_comb begin
        n_s7_mid.ray    = w_sq_ctl.ray;
        n_s7_mid.center = w_sq_ctl.center;
        if (w_sq_ctl.still) begin
            n_s7_mid.kind = w_sq_ctl.in_sph ? KIND_STAT : KIND_MISS;
        end else if (w_sq_ctl.miss) begin
            n_s7_mid.kind = KIND_MISS;
        end else if ((!w_sq_ctl.bneg && w_sq_ctl.bmag != '0) || (w_sq_root > w_sq_ctl.bmag)) begin
            n_s7_mid.kind = w_sq_ctl.in_sph ? KIND_STAT : KIND_MISS;
        end else begin
            n_s7_mid.kind = KIND_MOVE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s7_mid <= n_s7_mid;
        r_s7_num <= NUMW'(w_sq_ctl.bmag - w_sq_root) << FRAC_BITS;
        r_s7_a   <= w_sq_ctl.a;
        r_s7_mm  <= w_sq_ctl.mm;
    end

    // entry time and offset length run side by side, both 32 stages
    logic [DIV_QB-1:0]       w_td_quo;
    logic                    w_td_sat;
    logic [$bits(t_mid)-1:0] w_td_side;
    t_mid                    w_td_mid;
    logic [31:0]             w_len;

    rsc_div #(
        .NW (NUMW),
        .DW (64),
        .QB (DIV_QB),
        .SW ($bits(t_mid))
    ) u_div_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s7_vld),
        .i_num   (r_s7_num),
        .i_den   (r_s7_a),
        .i_side  (r_s7_mid),
        .o_vld   (w_td_vld),
        .o_quo   (w_td_quo),
        .o_sat   (w_td_sat),
        .o_side  (w_td_side)
    );

    rsc_sqrt #(
        .RB (32),
        .SW (1)
    ) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s7_vld),
        .i_val   (r_s7_mm),
        .i_side  (1'b0),
        .o_vld   (),
        .o_root  (w_len),
        .o_side  ()
    );

    assign w_td_mid = t_mid'(w_td_side);

    // stage 8: displacement times entry time
    logic [30:0]        n_s8_t;
    logic signed [63:0] n_s8_prod [3];
    logic [30:0]        r_s8_t;
    logic signed [63:0] r_s8_prod [3];
    t_mid               r_s8_mid;
    logic [31:0]        r_s8_len;

    always_comb begin
        n_s8_t = '0;
        if (w_td_mid.kind == KIND_MOVE) begin
            n_s8_t = w_td_sat ? Q_MAX : w_td_quo;
        end
        for (int i = 0; i < 3; i++) begin
            n_s8_prod[i] = $signed(w_td_mid.ray.d[i]) * $signed({1'b0, n_s8_t});
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8_t    <= n_s8_t;
        r_s8_prod <= n_s8_prod;
        r_s8_mid  <= w_td_mid;
        r_s8_len  <= w_len;
    end

    // stage 9: hit point and normal numerators
    logic signed [63:0] n_s9_dt  [3];
    logic signed [63:0] n_s9_nm  [3];
    logic [63:0]        n_s9_mag [3];
    logic [63:0]        n_s9_num [3];
    t_sgn               n_s9_sgn [3];
    t_tail              n_s9_tail;
    logic [63:0]        r_s9_num [3];
    t_sgn               r_s9_sgn [3];
    t_tail              r_s9_tail;
    logic [31:0]        r_s9_den;

    always_comb begin
        n_s9_tail.kind   = r_s8_mid.kind;
        n_s9_tail.center = r_s8_mid.center;
        n_s9_tail.hit_t  = r_s8_t;
        for (int i = 0; i < 3; i++) begin
            n_s9_dt[i]            = r_s8_prod[i] >>> FRAC_BITS;
            n_s9_tail.point[i]    = sat32(64'($signed(r_s8_mid.ray.p[i])) + n_s9_dt[i]);
            n_s9_nm[i]            = 64'($signed(r_s8_mid.ray.m[i])) + n_s9_dt[i];
            n_s9_sgn[i].neg       = n_s9_nm[i][63];
            n_s9_mag[i]           = n_s9_sgn[i].neg ? 64'(-n_s9_nm[i]) : 64'(n_s9_nm[i]);
            n_s9_sgn[i].zero      = n_s9_mag[i] == '0;
            n_s9_num[i]           = n_s9_mag[i] << FRAC_BITS;
        end
        n_s9_tail.sx = n_s9_sgn[0];
    end

    always_ff @(posedge i_clk) begin
        r_s9_num  <= n_s9_num;
        r_s9_sgn  <= n_s9_sgn;
        r_s9_tail <= n_s9_tail;
        r_s9_den  <= (r_s8_mid.kind == KIND_MOVE) ? {1'b0, r_s8_mid.ray.rad} : r_s8_len;
    end

    // normal dividers
    logic [DIV_QB-1:0]        w_nx_quo, w_ny_quo, w_nz_quo;
    logic                     w_nx_sat, w_ny_sat, w_nz_sat;
    logic [$bits(t_tail)-1:0] w_nx_side;
    logic [$bits(t_sgn)-1:0]  w_ny_side, w_nz_side;
    t_tail                    w_nd_tail;

    rsc_div #(
        .NW (64),
        .DW (32),
        .QB (DIV_QB),
        .SW ($bits(t_tail))
    ) u_div_nx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s9_vld),
        .i_num   (r_s9_num[0]),
        .i_den   (r_s9_den),
        .i_side  (r_s9_tail),
        .o_vld   (w_nd_vld),
        .o_quo   (w_nx_quo),
        .o_sat   (w_nx_sat),
        .o_side  (w_nx_side)
    );

    rsc_div #(
        .NW (64),
        .DW (32),
        .QB (DIV_QB),
        .SW ($bits(t_sgn))
    ) u_div_ny (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s9_vld),
        .i_num   (r_s9_num[1]),
        .i_den   (r_s9_den),
        .i_side  (r_s9_sgn[1]),
        .o_vld   (),
        .o_quo   (w_ny_quo),
        .o_sat   (w_ny_sat),
        .o_side  (w_ny_side)
    );

    rsc_div #(
        .NW (64),
        .DW (32),
        .QB (DIV_QB),
        .SW ($bits(t_sgn))
    ) u_div_nz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s9_vld),
        .i_num   (r_s9_num[2]),
        .i_den   (r_s9_den),
        .i_side  (r_s9_sgn[2]),
        .o_vld   (),
        .o_quo   (w_nz_quo),
        .o_sat   (w_nz_sat),
        .o_side  (w_nz_side)
    );

    assign w_nd_tail = t_tail'(w_nx_side);

    // result register
    logic        n_out_hit;
    logic [30:0] n_out_t;
    t_vec3       n_out_point;
    t_vec3       n_out_norm;
    logic        r_out_hit;
    logic [30:0] r_out_t;
    t_vec3       r_out_point;
    t_vec3       r_out_norm;

    always_comb begin
        n_out_hit   = 1'b0;
        n_out_t     = '0;
        n_out_point = '0;
        n_out_norm  = '0;
        unique case (w_nd_tail.kind)
            KIND_MOVE: begin
                n_out_hit     = 1'b1;
                n_out_t       = w_nd_tail.hit_t;
                n_out_point   = w_nd_tail.point;
                n_out_norm[0] = norm_q(w_nx_quo, w_nx_sat, w_nd_tail.sx);
                n_out_norm[1] = norm_q(w_ny_quo, w_ny_sat, t_sgn'(w_ny_side));
                n_out_norm[2] = norm_q(w_nz_quo, w_nz_sat, t_sgn'(w_nz_side));
            end
            KIND_STAT: begin
                n_out_hit   = 1'b1;
                n_out_point = w_nd_tail.point;
                if (w_nd_tail.center) begin
                    n_out_norm[0] = norm_q(w_nx_quo, w_nx_sat, w_nd_tail.sx);
                    n_out_norm[1] = norm_q(w_ny_quo, w_ny_sat, t_sgn'(w_ny_side));
                    n_out_norm[2] = norm_q(w_nz_quo, w_nz_sat, t_sgn'(w_nz_side));
                end else begin
                    n_out_norm[2] = ONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_hit   <= n_out_hit;
        r_out_t     <= n_out_t;
        r_out_point <= n_out_point;
        r_out_norm  <= n_out_norm;
    end

    assign o_done     = r_out_vld;
    assign o_hit      = r_out_hit;
    assign o_hit_time = r_out_t;
    assign o_point_x  = $signed(r_out_point[0]);
    assign o_point_y  = $signed(r_out_point[1]);
    assign o_point_z  = $signed(r_out_point[2]);
    assign o_normal_x = $signed(r_out_norm[0]);
    assign o_normal_y = $signed(r_out_norm[1]);
    assign o_normal_z = $signed(r_out_norm[2]);

    // checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("request did not complete after pipeline latency");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

    a_miss_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_time == '0 && o_point_x == '0 && o_normal_z == '0))
        else $error("miss result not cleared");

    a_eps_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_motion_eps_en |-> (r_motion_eps == $past(i_cfg_wdata)))
        else $error("motion threshold write lost");

endmodule
